[design/ntpc_pkg.sv]
// ----------------------------------------------------------------------------
// ntpc_pkg
// Shared types and constants of the nearest-template pose classifier.
// ----------------------------------------------------------------------------
package ntpc_pkg;

  localparam int QUAT_W     = 64;
  localparam int COMP_W     = 16;
  localparam int QUAT_COMPS = 4;
  localparam int SQ_W       = 2 * COMP_W;
  localparam int DIST_W     = 37;
  localparam int CLASS_W    = 5;
  localparam int IN_FINGERS = 5;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tok_t;

endpackage

[design/nearest_template_pose_classifier_unit.sv]
// ----------------------------------------------------------------------------
// nearest_template_pose_classifier_unit
// Nearest-template hand pose classifier over a row of finger cells.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | cmd, entry_index, finger0..4_quat
//   out_    | output    | out_valid/out_ready | class_index, min_distance
//
// A load transfer writes all finger columns in the same cycle.
// A classify walks one template per cycle into the cell row; out_valid rises
// after the template walk, the hand-off register of each earlier cell, the
// three stages of the last cell and the result select, once the output
// register is free to take the result.
// No new input is taken until the result sits in the output register.
// Reset is synchronous; template contents are not cleared.
// ----------------------------------------------------------------------------
module nearest_template_pose_classifier_unit import ntpc_pkg::*; #(
  parameter int NUM_TEMPLATES = 26,
  parameter int NUM_FINGERS   = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [4:0]         in_entry_index,
  input  logic [QUAT_W-1:0]  in_finger0_quat,
  input  logic [QUAT_W-1:0]  in_finger1_quat,
  input  logic [QUAT_W-1:0]  in_finger2_quat,
  input  logic [QUAT_W-1:0]  in_finger3_quat,
  input  logic [QUAT_W-1:0]  in_finger4_quat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CLASS_W-1:0] out_class_index,
  output logic [DIST_W-1:0]  out_min_distance
);

  localparam int AW = $clog2(NUM_TEMPLATES);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TEMPLATES - 1);

  logic [QUAT_W-1:0] in_quat [IN_FINGERS];
  logic              in_xfer;
  logic              load_we;
  logic [AW-1:0]     load_addr;

  logic              busy_r;
  logic              seq_run_r;
  logic [AW-1:0]     seq_idx_r;
  logic              res_pend_r;
  logic [DIST_W-1:0] best_r;
  logic [AW-1:0]     best_idx_r;
  logic              out_valid_r;
  logic [CLASS_W-1:0] out_class_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic              out_move;

  tok_t              chain_tok [NUM_FINGERS+1];
  logic [AW-1:0]     chain_idx [NUM_FINGERS+1];
  logic [DIST_W-1:0] chain_sum [NUM_FINGERS+1];
  tok_t              fin_tok   [NUM_FINGERS];
  logic [AW-1:0]     fin_idx   [NUM_FINGERS];
  logic [QUAT_W-1:0] lane_query [NUM_FINGERS];
  logic [QUAT_W-1:0] lane_wdata [NUM_FINGERS];
  logic              lane_we    [NUM_FINGERS];

  tok_t              last_tok;
  logic [AW-1:0]     last_idx;
  logic [DIST_W-1:0] last_sum;

  assign in_quat[0] = in_finger0_quat;
  assign in_quat[1] = in_finger1_quat;
  assign in_quat[2] = in_finger2_quat;
  assign in_quat[3] = in_finger3_quat;
  assign in_quat[4] = in_finger4_quat;

  assign in_ready  = !busy_r;
  assign in_xfer   = in_valid && in_ready;
  assign load_we   = in_xfer && (in_cmd == CMD_LOAD)
                     && (in_entry_index < NUM_TEMPLATES);
  assign load_addr = AW'(in_entry_index);

  assign chain_tok[0] = '{vld: seq_run_r, first: (seq_idx_r == '0),
                          last: (seq_idx_r == LAST_IDX)};
  assign chain_idx[0] = seq_idx_r;
  assign chain_sum[0] = '0;

  for (genvar f = 0; f < NUM_FINGERS; f++) begin : g_cell
    if (f < IN_FINGERS) begin : g_live
      logic [QUAT_W-1:0] query_r;
      always_ff @(posedge clk) begin
        if (in_xfer && (in_cmd == CMD_CLASSIFY)) begin
          query_r <= in_quat[f];
        end
      end
      assign lane_query[f] = query_r;
      assign lane_wdata[f] = in_quat[f];
      assign lane_we[f]    = load_we;
    end else begin : g_extra
      assign lane_query[f] = '0;
      assign lane_wdata[f] = '0;
      assign lane_we[f]    = 1'b0;
    end

    ntpc_cell #(
      .NUM_TEMPLATES (NUM_TEMPLATES)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (lane_we[f]),
      .wr_addr (load_addr),
      .wr_data (lane_wdata[f]),
      .query   (lane_query[f]),
      .tok_in  (chain_tok[f]),
      .idx_in  (chain_idx[f]),
      .sum_in  (chain_sum[f]),
      .tok_out (chain_tok[f+1]),
      .idx_out (chain_idx[f+1]),
      .fin_tok (fin_tok[f]),
      .fin_idx (fin_idx[f]),
      .sum_out (chain_sum[f+1])
    );
  end

  assign last_tok = fin_tok[NUM_FINGERS-1];
  assign last_idx = fin_idx[NUM_FINGERS-1];
  assign last_sum = chain_sum[NUM_FINGERS];

  assign out_move = res_pend_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      seq_run_r   <= 1'b0;
      seq_idx_r   <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer && (in_cmd == CMD_CLASSIFY)) begin
        busy_r    <= 1'b1;
        seq_run_r <= 1'b1;
        seq_idx_r <= '0;
      end else if (seq_run_r) begin
        if (seq_idx_r == LAST_IDX) begin
          seq_run_r <= 1'b0;
        end
        seq_idx_r <= seq_idx_r + 1'b1;
      end

      if (last_tok.vld && last_tok.last) begin
        res_pend_r <= 1'b1;
      end else if (out_move) begin
        res_pend_r <= 1'b0;
        busy_r     <= 1'b0;
      end

      if (out_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last_tok.vld && (last_tok.first || (last_sum < best_r))) begin
      best_r     <= last_sum;
      best_idx_r <= last_idx;
    end
    if (out_move) begin
      out_class_r <= CLASS_W'(best_idx_r);
      out_dist_r  <= best_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_class_index  = out_class_r;
  assign out_min_distance = out_dist_r;

  a_seq_in_busy : assert property (@(posedge clk) disable iff (!rst_n)
    seq_run_r |-> busy_r)
    else $error("template walk running outside a classify");

  a_fin_in_busy : assert property (@(posedge clk) disable iff (!rst_n)
    last_tok.vld |-> busy_r)
    else $error("cell row output without a classify in flight");

  a_pend_after_walk : assert property (@(posedge clk) disable iff (!rst_n)
    res_pend_r |-> !seq_run_r)
    else $error("result pending while templates still issue");

  a_out_from_pend : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_pend_r))
    else $error("output raised without a pending result");

endmodule

[design/ntpc_ram.sv]
// ----------------------------------------------------------------------------
// ntpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ntpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 26,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/ntpc_cell.sv]
// ----------------------------------------------------------------------------
// ntpc_cell
// One finger cell: holds that finger's template column, squares the
// component differences and adds them onto the running distance.
// ----------------------------------------------------------------------------
module ntpc_cell import ntpc_pkg::*; #(
  parameter int NUM_TEMPLATES = 26,
  localparam int AW = $clog2(NUM_TEMPLATES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [QUAT_W-1:0] wr_data,
  input  logic [QUAT_W-1:0] query,
  input  tok_t              tok_in,
  input  logic [AW-1:0]     idx_in,
  input  logic [DIST_W-1:0] sum_in,
  output tok_t              tok_out,
  output logic [AW-1:0]     idx_out,
  output tok_t              fin_tok,
  output logic [AW-1:0]     fin_idx,
  output logic [DIST_W-1:0] sum_out
);

  logic [QUAT_W-1:0] tpl_rdata;
  tok_t              tok_a_r, tok_b_r, tok_c_r;
  logic [AW-1:0]     idx_a_r, idx_b_r, idx_c_r;
  logic [SQ_W-1:0]   sq_r [QUAT_COMPS];
  logic [DIST_W-1:0] sum_r;
  logic [DIST_W-1:0] sum_nxt;
  logic [COMP_W:0]   diff [QUAT_COMPS];
  logic [COMP_W:0]   absd [QUAT_COMPS];

  ntpc_ram #(
    .WIDTH (QUAT_W),
    .DEPTH (NUM_TEMPLATES)
  ) u_tpl_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_in),
    .rd_data (tpl_rdata)
  );

  always_comb begin
    for (int c = 0; c < QUAT_COMPS; c++) begin
      diff[c] = {query[c*COMP_W + COMP_W-1], query[c*COMP_W +: COMP_W]}
              - {tpl_rdata[c*COMP_W + COMP_W-1], tpl_rdata[c*COMP_W +: COMP_W]};
      absd[c] = diff[c][COMP_W] ? (~diff[c] + 1'b1) : diff[c];
    end
  end

  always_comb begin
    sum_nxt = sum_in;
    for (int c = 0; c < QUAT_COMPS; c++) begin
      sum_nxt = sum_nxt + DIST_W'(sq_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r <= '0;
      tok_b_r <= '0;
      tok_c_r <= '0;
    end else begin
      tok_a_r <= tok_in;
      tok_b_r <= tok_a_r;
      tok_c_r <= tok_b_r;
    end
  end

  always_ff @(posedge clk) begin
    idx_a_r <= idx_in;
    idx_b_r <= idx_a_r;
    idx_c_r <= idx_b_r;
    for (int c = 0; c < QUAT_COMPS; c++) begin
      sq_r[c] <= absd[c][COMP_W-1:0] * absd[c][COMP_W-1:0];
    end
    sum_r <= sum_nxt;
  end

  assign tok_out = tok_a_r;
  assign idx_out = idx_a_r;
  assign fin_tok = tok_c_r;
  assign fin_idx = idx_c_r;
  assign sum_out = sum_r;

endmodule

[tb/sv/tb_nearest_template_pose_classifier_unit.sv]
// ----------------------------------------------------------------------------
// tb_nearest_template_pose_classifier_unit
// Self-checking bench for the nearest-template pose classifier. Every accepted
// in-range load updates a local copy of the template table, and every accepted
// classify predicts the nearest template index and its exact squared distance.
// Returned results are checked in order against those predictions. The template
// table is filled completely before the first classify, and random traffic then
// runs under several sender and receiver throttling phases.
// ----------------------------------------------------------------------------
module tb_nearest_template_pose_classifier_unit import ntpc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEMPLATE_COUNT = 26;
  localparam int FINGER_COUNT   = IN_FINGERS;
  localparam int PHASE_ITEMS    = 200;
  localparam int TAIL_CYCLES    = TEMPLATE_COUNT + FINGER_COUNT + 4 + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 64'd1;
  localparam logic [QUAT_W-1:0] QUAT_MOST_NEG = 64'h8000_8000_8000_8000;
  localparam logic [QUAT_W-1:0] QUAT_MOST_POS = 64'h7FFF_7FFF_7FFF_7FFF;
  localparam logic [QUAT_W-1:0] QUAT_ZERO     = 64'h0000_0000_0000_0000;
  localparam logic [QUAT_W-1:0] QUAT_MINUS_1  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [QUAT_W-1:0] QUAT_LSB      = 64'h0001_0001_0001_0001;

  localparam int SHAPE_RANDOM  = 0;
  localparam int SHAPE_EXTREME = 1;
  localparam int SHAPE_NEAR    = 2;
  localparam int SHAPE_COPY    = 3;

  typedef struct packed {
    logic                                  cmd;
    logic [4:0]                            entry_index;
    logic [FINGER_COUNT-1:0][QUAT_W-1:0]   fingers;
  } pose_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic [DIST_W-1:0]  min_distance;
  } class_match_t;

  class nearest_pose_board;
    logic [QUAT_W-1:0] template_mirror [TEMPLATE_COUNT][FINGER_COUNT];
    class_match_t      pending_matches [$];
    int                mismatch_count;

    function new();
      mismatch_count = 0;
      foreach (template_mirror[t, f]) template_mirror[t][f] = '0;
    endfunction

    function class_match_t nearest_template(pose_item_t p);
      class_match_t           best;
      longint unsigned        sum;
      longint                 d;
      logic signed [COMP_W-1:0] a;
      logic signed [COMP_W-1:0] b;
      best = '0;
      for (int t = 0; t < TEMPLATE_COUNT; t++) begin
        sum = 0;
        for (int f = 0; f < FINGER_COUNT; f++) begin
          for (int c = 0; c < QUAT_COMPS; c++) begin
            a = p.fingers[f][c*COMP_W +: COMP_W];
            b = template_mirror[t][f][c*COMP_W +: COMP_W];
            d = longint'(a) - longint'(b);
            sum += d * d;
          end
        end
        if (sum > DIST_LIMIT) sum = DIST_LIMIT;
        if (t == 0 || sum < best.min_distance) begin
          best.min_distance = sum[DIST_W-1:0];
          best.class_index  = CLASS_W'(t);
        end
      end
      return best;
    endfunction

    function void take_pose_transfer(pose_item_t p);
      if (p.cmd == CMD_LOAD) begin
        if (p.entry_index < TEMPLATE_COUNT)
          for (int f = 0; f < FINGER_COUNT; f++)
            template_mirror[p.entry_index][f] = p.fingers[f];
      end else begin
        pending_matches.push_back(nearest_template(p));
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
    endtask

    task check_class_result(class_match_t got);
      class_match_t exp;
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: class %0d distance %0d",
                                  got.class_index, got.min_distance));
      end else begin
        exp = pending_matches.pop_front();
        if (got.class_index !== exp.class_index)
          report_mismatch($sformatf("class_index got %0d exp %0d",
                                    got.class_index, exp.class_index));
        if (got.min_distance !== exp.min_distance)
          report_mismatch($sformatf("min_distance got %0d exp %0d",
                                    got.min_distance, exp.min_distance));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n            = 1'b0;
  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic              in_cmd           = CMD_LOAD;
  logic [4:0]        in_entry_index   = '0;
  logic [QUAT_W-1:0] in_finger0_quat  = '0;
  logic [QUAT_W-1:0] in_finger1_quat  = '0;
  logic [QUAT_W-1:0] in_finger2_quat  = '0;
  logic [QUAT_W-1:0] in_finger3_quat  = '0;
  logic [QUAT_W-1:0] in_finger4_quat  = '0;
  logic              out_valid;
  logic              out_ready        = 1'b0;
  logic [CLASS_W-1:0] out_class_index;
  logic [DIST_W-1:0]  out_min_distance;

  nearest_pose_board board;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                quiet_cycles   = 0;

  logic [COMP_W-1:0] comp_extremes [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

  nearest_template_pose_classifier_unit #(
    .NUM_TEMPLATES(TEMPLATE_COUNT),
    .NUM_FINGERS  (FINGER_COUNT)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_entry_index  (in_entry_index),
    .in_finger0_quat (in_finger0_quat),
    .in_finger1_quat (in_finger1_quat),
    .in_finger2_quat (in_finger2_quat),
    .in_finger3_quat (in_finger3_quat),
    .in_finger4_quat (in_finger4_quat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_class_index (out_class_index),
    .out_min_distance(out_min_distance)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    pose_item_t   seen;
    class_match_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.cmd         = in_cmd;
        seen.entry_index = in_entry_index;
        seen.fingers     = {in_finger4_quat, in_finger3_quat, in_finger2_quat,
                            in_finger1_quat, in_finger0_quat};
        board.take_pose_transfer(seen);
      end
      if (out_valid && out_ready) begin
        got.class_index  = out_class_index;
        got.min_distance = out_min_distance;
        board.check_class_result(got);
      end
      quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
                      0 : quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [QUAT_W-1:0] shaped_quat(int shape, logic [QUAT_W-1:0] base);
    logic [QUAT_W-1:0] q;
    int                spread;
    q = {$urandom, $urandom};
    spread = $urandom_range(1, 64);
    for (int c = 0; c < QUAT_COMPS; c++) begin
      case (shape)
        SHAPE_EXTREME: q[c*COMP_W +: COMP_W] = comp_extremes[$urandom_range(4)];
        SHAPE_NEAR:    q[c*COMP_W +: COMP_W] = base[c*COMP_W +: COMP_W]
                                               + COMP_W'($urandom_range(2 * spread))
                                               - COMP_W'(spread);
        SHAPE_COPY:    q[c*COMP_W +: COMP_W] = base[c*COMP_W +: COMP_W];
        default: ;
      endcase
    end
    return q;
  endfunction

  function automatic pose_item_t make_pose(logic cmd, logic [4:0] slot, int shape, int src);
    pose_item_t p;
    p.cmd         = cmd;
    p.entry_index = slot;
    for (int f = 0; f < FINGER_COUNT; f++)
      p.fingers[f] = shaped_quat(shape, board.template_mirror[src][f]);
    return p;
  endfunction

  function automatic pose_item_t uniform_pose(logic cmd, logic [4:0] slot,
                                               logic [QUAT_W-1:0] q);
    pose_item_t p;
    p.cmd         = cmd;
    p.entry_index = slot;
    for (int f = 0; f < FINGER_COUNT; f++) p.fingers[f] = q;
    return p;
  endfunction

  function automatic pose_item_t random_pose();
    int         roll;
    int         pick;
    int         src;
    logic [4:0] slot;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    src  = $urandom_range(TEMPLATE_COUNT - 1);
    if (roll < 30) begin
      slot = ($urandom_range(19) == 0) ? 5'($urandom_range(31, TEMPLATE_COUNT))
                                        : 5'($urandom_range(TEMPLATE_COUNT - 1));
      return make_pose(CMD_LOAD, slot,
                       (pick < 65) ? SHAPE_RANDOM : (pick < 80) ? SHAPE_NEAR :
                       (pick < 90) ? SHAPE_COPY : SHAPE_EXTREME, src);
    end
    slot = 5'($urandom_range(31));
    return make_pose(CMD_CLASSIFY, slot,
                     (pick < 25) ? SHAPE_COPY : (pick < 65) ? SHAPE_NEAR :
                     (pick < 85) ? SHAPE_RANDOM : SHAPE_EXTREME, src);
  endfunction

  task automatic send_pose(pose_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= p.cmd;
    in_entry_index  <= p.entry_index;
    in_finger0_quat <= p.fingers[0];
    in_finger1_quat <= p.fingers[1];
    in_finger2_quat <= p.fingers[2];
    in_finger3_quat <= p.fingers[3];
    in_finger4_quat <= p.fingers[4];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_matches.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [QUAT_W-1:0] fill [TEMPLATE_COUNT][FINGER_COUNT];
    pose_item_t        probe;

    board = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every template at the most negative value: worst-case distance, full tie
    for (int t = 0; t < TEMPLATE_COUNT; t++)
      send_pose(uniform_pose(CMD_LOAD, 5'(t), QUAT_MOST_NEG));
    send_pose(uniform_pose(CMD_CLASSIFY, 5'd0, QUAT_MOST_POS));
    send_pose(uniform_pose(CMD_CLASSIFY, 5'd31, QUAT_MOST_NEG));

    foreach (fill[t, f]) fill[t][f] = {$urandom, $urandom};
    for (int f = 0; f < FINGER_COUNT; f++) begin
      fill[0][f] = QUAT_MOST_NEG;
      fill[1][f] = QUAT_MOST_POS;
      fill[2][f] = QUAT_ZERO;
      fill[3][f] = fill[5][f];
    end
    for (int t = 0; t < TEMPLATE_COUNT; t++) begin
      probe.cmd         = CMD_LOAD;
      probe.entry_index = 5'(t);
      for (int f = 0; f < FINGER_COUNT; f++) probe.fingers[f] = fill[t][f];
      send_pose(probe);
    end

    // loads beyond the table must not land anywhere
    send_pose(uniform_pose(CMD_LOAD, 5'(TEMPLATE_COUNT), QUAT_LSB));
    probe = make_pose(CMD_LOAD, 5'd31, SHAPE_RANDOM, 0);
    send_pose(probe);
    probe.cmd = CMD_CLASSIFY;
    send_pose(probe);
    send_pose(uniform_pose(CMD_CLASSIFY, 5'd7, QUAT_LSB));
    send_pose(uniform_pose(CMD_CLASSIFY, 5'd0, QUAT_MINUS_1));
    send_pose(uniform_pose(CMD_CLASSIFY, 5'd0, QUAT_MOST_POS));
    send_pose(make_pose(CMD_CLASSIFY, 5'd0, SHAPE_COPY, 5));
    send_pose(make_pose(CMD_CLASSIFY, 5'd31, SHAPE_COPY, 7));
    send_pose(make_pose(CMD_CLASSIFY, 5'd16, SHAPE_NEAR, 20));
    send_pose(make_pose(CMD_CLASSIFY, 5'd1, SHAPE_EXTREME, 0));
    send_pose(make_pose(CMD_LOAD, 5'd25, SHAPE_COPY, 0));
    send_pose(uniform_pose(CMD_CLASSIFY, 5'd0, QUAT_MOST_NEG));
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_pose(random_pose());
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
